// ===== src/crsp_pkg.sv =====
// ============================================================================
// crsp_pkg: shared types and constants of the Catmull-Rom point unit
// Coordinate, difference, weight and accumulator formats, and the structs
// that carry one item between the front end, the queue and the datapath.
// ============================================================================
package crsp_pkg;

    localparam int COORD_W          = 24;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int S_FRAC           = 16;
    localparam int WEIGHT_W         = S_FRAC + 4;
    localparam int ACC_W            = 48;
    localparam int RND_W            = ACC_W - S_FRAC - 1;
    localparam int STEP_COUNT_RESET = 100;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RND_W-1:0]    rnd_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        point_t p3;
        point_t p2;
        point_t p1;
        point_t p0;
    } quad_t;

    // per-axis operands: endpoints plus the three differences the weights act on
    typedef struct packed {
        coord_t p1;
        coord_t p2;
        diff_t  d21;
        diff_t  d20;
        diff_t  d31;
    } axis_t;

    typedef struct packed {
        logic  oor;
        axis_t x;
        axis_t y;
    } carry_t;

    typedef struct packed {
        acc_t t1;
        acc_t t2;
        acc_t t3;
    } prod_set_t;

    typedef struct packed {
        acc_t a;
        acc_t b;
    } pair_t;

endpackage

// ===== src/crsp_front.sv =====
// ============================================================================
// crsp_front: input stage
// Registers an incoming item, flags a step index past the segment end and
// forms the point differences used by the datapath.
// ============================================================================
module crsp_front #(
    parameter int STEP_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  crsp_pkg::quad_t       in_pts,
    input  logic [STEP_BITS-1:0]  in_step,
    input  logic [STEP_BITS-1:0]  step_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STEP_BITS-1:0]  out_step,
    output crsp_pkg::carry_t      out_info
);

    logic                 valid_reg;
    logic [STEP_BITS-1:0] step_reg;
    crsp_pkg::carry_t     info_reg;
    crsp_pkg::carry_t     info_next;

    function automatic crsp_pkg::axis_t make_axis(crsp_pkg::coord_t a0, crsp_pkg::coord_t a1,
                                                  crsp_pkg::coord_t a2, crsp_pkg::coord_t a3);
        crsp_pkg::axis_t r;
        r.p1  = a1;
        r.p2  = a2;
        r.d21 = crsp_pkg::diff_t'(a2) - crsp_pkg::diff_t'(a1);
        r.d20 = crsp_pkg::diff_t'(a2) - crsp_pkg::diff_t'(a0);
        r.d31 = crsp_pkg::diff_t'(a3) - crsp_pkg::diff_t'(a1);
        return r;
    endfunction

    always_comb begin
        // a step count of zero puts every index past the end
        info_next.oor = (in_step >= step_count);
        info_next.x   = make_axis(in_pts.p0.x, in_pts.p1.x, in_pts.p2.x, in_pts.p3.x);
        info_next.y   = make_axis(in_pts.p0.y, in_pts.p1.y, in_pts.p2.y, in_pts.p3.y);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_step  = step_reg;
    assign out_info  = info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            step_reg <= in_step;
            info_reg <= info_next;
        end
    end

endmodule

// ===== src/crsp_fifo.sv =====
// ============================================================================
// crsp_fifo: short item queue
// Register-based FIFO between the front end and the datapath so that each
// side can stall without holding up the other.
// ============================================================================
module crsp_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  item_t                      in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output item_t                      out_item,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign level     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== src/crsp_div.sv =====
// ============================================================================
// crsp_div: pipelined step divider
// Restoring division of step_index * 2^16 by the step count, one quotient bit
// per stage, with the item's operands carried alongside.
// ============================================================================
module crsp_div #(
    parameter int STEP_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [STEP_BITS-1:0]         in_num,
    input  logic [STEP_BITS-1:0]         divisor,
    input  crsp_pkg::carry_t             in_info,
    output logic                         out_valid,
    output logic [crsp_pkg::S_FRAC-1:0]  out_quot,
    output crsp_pkg::carry_t             out_info
);

    localparam int STAGES = crsp_pkg::S_FRAC;

    logic                 valid_reg [STAGES];
    logic [STEP_BITS-1:0] rem_reg   [STAGES-1];
    logic [STAGES-1:0]    quot_reg  [STAGES];
    crsp_pkg::carry_t     info_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 prev_valid;
        logic [STEP_BITS-1:0] prev_rem;
        logic [STAGES-1:0]    prev_quot;
        crsp_pkg::carry_t     prev_info;
        logic [STEP_BITS:0]   rem_dbl;
        logic [STEP_BITS:0]   rem_sub;
        logic                 take;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_num;
            assign prev_quot  = '0;
            assign prev_info  = in_info;
        end else begin : g_rest
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_quot  = quot_reg[k-1];
            assign prev_info  = info_reg[k-1];
        end

        assign rem_dbl = {prev_rem, 1'b0};
        assign take    = (rem_dbl >= {1'b0, divisor});
        assign rem_sub = rem_dbl - {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[k] <= {prev_quot[STAGES-2:0], take};
                info_reg[k] <= prev_info;
            end
        end

        // the last stage needs no remainder
        if (k < STAGES - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? rem_sub[STEP_BITS-1:0] : rem_dbl[STEP_BITS-1:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_info  = info_reg[STAGES-1];

endmodule

// ===== src/crsp_back.sv =====
// ============================================================================
// crsp_back: evaluation datapath
// Divides out s, builds s^2, s^3 and the Hermite weights, forms the weighted
// sums, rounds and saturates, or gives P2 past the segment end. The whole pipe
// advances together and holds while a finished point waits at the output.
// ============================================================================
module crsp_back #(
    parameter int STEP_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [STEP_BITS-1:0]  in_step,
    input  crsp_pkg::carry_t      in_info,
    input  logic [STEP_BITS-1:0]  step_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crsp_pkg::coord_t      out_point_x,
    output crsp_pkg::coord_t      out_point_y,
    output logic                  out_oor
);

    localparam int SF = crsp_pkg::S_FRAC;
    localparam int WP = crsp_pkg::WEIGHT_W + crsp_pkg::DIFF_W;

    logic                adv;
    logic                div_valid;
    logic [SF-1:0]       div_quot;
    crsp_pkg::carry_t    div_info;

    logic                sq_valid_reg;
    logic [SF-1:0]       sq_s_reg;
    logic [SF-1:0]       sq_sq_reg;
    crsp_pkg::carry_t    sq_info_reg;
    logic [2*SF-1:0]     sq_full;

    logic                cu_valid_reg;
    logic [SF-1:0]       cu_s_reg;
    logic [SF-1:0]       cu_sq_reg;
    logic [SF-1:0]       cu_cu_reg;
    crsp_pkg::carry_t    cu_info_reg;
    logic [2*SF-1:0]     cu_full;

    logic                wt_valid_reg;
    crsp_pkg::weight_t   wt_h2_reg;
    crsp_pkg::weight_t   wt_h3_reg;
    crsp_pkg::weight_t   wt_h4_reg;
    crsp_pkg::carry_t    wt_info_reg;
    crsp_pkg::weight_t   se, qe, ce;

    logic                mul_valid_reg;
    crsp_pkg::prod_set_t mul_x_reg;
    crsp_pkg::prod_set_t mul_y_reg;
    crsp_pkg::carry_t    mul_info_reg;

    logic                sum_valid_reg;
    crsp_pkg::pair_t     sum_x_reg;
    crsp_pkg::pair_t     sum_y_reg;
    crsp_pkg::carry_t    sum_info_reg;

    logic                acc_valid_reg;
    crsp_pkg::acc_t      acc_x_reg;
    crsp_pkg::acc_t      acc_y_reg;
    crsp_pkg::carry_t    acc_info_reg;

    logic                rnd_valid_reg;
    crsp_pkg::rnd_t      rnd_x_reg;
    crsp_pkg::rnd_t      rnd_y_reg;
    crsp_pkg::carry_t    rnd_info_reg;

    logic                out_valid_reg;
    crsp_pkg::coord_t    out_x_reg;
    crsp_pkg::coord_t    out_y_reg;
    logic                out_oor_reg;

    function automatic crsp_pkg::prod_set_t axis_products(crsp_pkg::weight_t h2,
                                                          crsp_pkg::weight_t h3,
                                                          crsp_pkg::weight_t h4,
                                                          crsp_pkg::axis_t a);
        logic signed [WP-1:0] m2;
        logic signed [WP-1:0] m3;
        logic signed [WP-1:0] m4;
        crsp_pkg::prod_set_t r;
        m2   = h2 * a.d21;
        m3   = h3 * a.d20;
        m4   = h4 * a.d31;
        r.t1 = crsp_pkg::acc_t'(m2) <<< 1;
        r.t2 = crsp_pkg::acc_t'(m3);
        r.t3 = crsp_pkg::acc_t'(m4);
        return r;
    endfunction

    // 2*h1*P1 + 2*h2*P2 = 2^17*P1 + 2*h2*(P2 - P1), since h1 + h2 = 1
    function automatic crsp_pkg::pair_t axis_pair(crsp_pkg::prod_set_t p, crsp_pkg::coord_t p1);
        crsp_pkg::pair_t r;
        r.a = (crsp_pkg::acc_t'(p1) <<< (SF + 1)) + p.t1;
        r.b = p.t2 + p.t3;
        return r;
    endfunction

    // divide by 2^17, round half away from zero
    function automatic crsp_pkg::rnd_t round_acc(crsp_pkg::acc_t v);
        crsp_pkg::acc_t bias;
        crsp_pkg::acc_t sum;
        bias = v[crsp_pkg::ACC_W-1] ? crsp_pkg::acc_t'((1 << SF) - 1)
                                    : crsp_pkg::acc_t'(1 << SF);
        sum  = v + bias;
        return $signed(sum[crsp_pkg::ACC_W-1:SF+1]);
    endfunction

    function automatic crsp_pkg::coord_t sat_coord(crsp_pkg::rnd_t v);
        crsp_pkg::coord_t r;
        if (v > crsp_pkg::rnd_t'(crsp_pkg::COORD_MAX)) begin
            r = crsp_pkg::COORD_MAX;
        end else if (v < crsp_pkg::rnd_t'(crsp_pkg::COORD_MIN)) begin
            r = crsp_pkg::COORD_MIN;
        end else begin
            r = v[crsp_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    crsp_div #(
        .STEP_BITS (STEP_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (in_valid),
        .in_num    (in_step),
        .divisor   (step_count),
        .in_info   (in_info),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_info  (div_info)
    );

    assign sq_full = div_quot * div_quot;
    assign cu_full = sq_sq_reg * sq_s_reg;

    assign se = crsp_pkg::weight_t'({{(crsp_pkg::WEIGHT_W-SF){1'b0}}, cu_s_reg});
    assign qe = crsp_pkg::weight_t'({{(crsp_pkg::WEIGHT_W-SF){1'b0}}, cu_sq_reg});
    assign ce = crsp_pkg::weight_t'({{(crsp_pkg::WEIGHT_W-SF){1'b0}}, cu_cu_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            cu_valid_reg  <= 1'b0;
            wt_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            sq_valid_reg  <= div_valid;
            cu_valid_reg  <= sq_valid_reg;
            wt_valid_reg  <= cu_valid_reg;
            mul_valid_reg <= wt_valid_reg;
            sum_valid_reg <= mul_valid_reg;
            acc_valid_reg <= sum_valid_reg;
            rnd_valid_reg <= acc_valid_reg;
            out_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_s_reg     <= div_quot;
            sq_sq_reg    <= sq_full[2*SF-1:SF];
            sq_info_reg  <= div_info;

            cu_s_reg     <= sq_s_reg;
            cu_sq_reg    <= sq_sq_reg;
            cu_cu_reg    <= cu_full[2*SF-1:SF];
            cu_info_reg  <= sq_info_reg;

            wt_h2_reg    <= (qe <<< 1) + qe - (ce <<< 1);
            wt_h3_reg    <= ce - (qe <<< 1) + se;
            wt_h4_reg    <= ce - qe;
            wt_info_reg  <= cu_info_reg;

            mul_x_reg    <= axis_products(wt_h2_reg, wt_h3_reg, wt_h4_reg, wt_info_reg.x);
            mul_y_reg    <= axis_products(wt_h2_reg, wt_h3_reg, wt_h4_reg, wt_info_reg.y);
            mul_info_reg <= wt_info_reg;

            sum_x_reg    <= axis_pair(mul_x_reg, mul_info_reg.x.p1);
            sum_y_reg    <= axis_pair(mul_y_reg, mul_info_reg.y.p1);
            sum_info_reg <= mul_info_reg;

            acc_x_reg    <= sum_x_reg.a + sum_x_reg.b;
            acc_y_reg    <= sum_y_reg.a + sum_y_reg.b;
            acc_info_reg <= sum_info_reg;

            rnd_x_reg    <= round_acc(acc_x_reg);
            rnd_y_reg    <= round_acc(acc_y_reg);
            rnd_info_reg <= acc_info_reg;

            // past the segment end the point is P2 exactly
            out_x_reg    <= rnd_info_reg.oor ? rnd_info_reg.x.p2 : sat_coord(rnd_x_reg);
            out_y_reg    <= rnd_info_reg.oor ? rnd_info_reg.y.p2 : sat_coord(rnd_y_reg);
            out_oor_reg  <= rnd_info_reg.oor;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_point_x = out_x_reg;
    assign out_point_y = out_y_reg;
    assign out_oor     = out_oor_reg;

endmodule

// ===== src/catmull_rom_spline_point_unit.sv =====
// ============================================================================
// catmull_rom_spline_point_unit: Catmull-Rom segment point evaluator
// Takes four control points and a step index, returns the curve point at
// s = step_index / step_count in cubic Hermite form, saturated to Q16.8.
// ============================================================================
// One point comes out for every item in. The unit takes one item per clock
// and, with m_tready held high, returns one point per clock. An accepted item
// loads into the input register at the accepting edge, is written into the
// item queue, then passes the pipelined step divider (one quotient bit per
// stage) and the square, cube, weights, multiply, partial sum, final sum,
// round and saturate registers. While the result side is stalled the item queue
// (QUEUE_DEPTH entries) and the input register take up to QUEUE_DEPTH + 1 more
// items before s_tready drops. A step index at or past step_count returns P2
// with out_of_range set. step_count resets to 100. The user must write it on
// the cfg channel only while no transaction is in flight; the unit does not check.
module catmull_rom_spline_point_unit #(
    parameter int STEP_BITS   = 10,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, step_index, zero pad
    input  logic [((8*crsp_pkg::COORD_W + STEP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x, point_y
    output logic [2*crsp_pkg::COORD_W-1:0] m_tdata,
    // out_of_range
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [STEP_BITS-1:0]  cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int CW    = crsp_pkg::COORD_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [STEP_BITS-1:0] step;
        crsp_pkg::carry_t     info;
    } item_t;

    logic [STEP_BITS-1:0] step_count_reg;
    crsp_pkg::quad_t      in_pts;
    logic [STEP_BITS-1:0] in_step;

    logic                 front_valid;
    logic                 q_in_ready;
    item_t                front_item;
    logic                 q_out_valid;
    logic                 q_out_ready;
    item_t                q_item;
    logic [CNT_W-1:0]     q_level;
    crsp_pkg::coord_t     point_x;
    crsp_pkg::coord_t     point_y;

    assign in_pts.p0.x = s_tdata[0*CW +: CW];
    assign in_pts.p0.y = s_tdata[1*CW +: CW];
    assign in_pts.p1.x = s_tdata[2*CW +: CW];
    assign in_pts.p1.y = s_tdata[3*CW +: CW];
    assign in_pts.p2.x = s_tdata[4*CW +: CW];
    assign in_pts.p2.y = s_tdata[5*CW +: CW];
    assign in_pts.p3.x = s_tdata[6*CW +: CW];
    assign in_pts.p3.y = s_tdata[7*CW +: CW];
    assign in_step     = s_tdata[8*CW +: STEP_BITS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_BITS'(crsp_pkg::STEP_COUNT_RESET);
        end else if (cfg_valid && cfg_ready) begin
            step_count_reg <= cfg_data;
        end
    end

    crsp_front #(
        .STEP_BITS (STEP_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pts     (in_pts),
        .in_step    (in_step),
        .step_count (step_count_reg),
        .out_valid  (front_valid),
        .out_ready  (q_in_ready),
        .out_step   (front_item.step),
        .out_info   (front_item.info)
    );

    crsp_fifo #(
        .item_t (item_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (q_in_ready),
        .in_item   (front_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_item),
        .level     (q_level)
    );

    crsp_back #(
        .STEP_BITS (STEP_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_out_valid),
        .in_ready    (q_out_ready),
        .in_step     (q_item.step),
        .in_info     (q_item.info),
        .step_count  (step_count_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_point_x (point_x),
        .out_point_y (point_y),
        .out_oor     (m_tuser)
    );

    assign m_tdata = {point_y, point_x};

    // queue occupancy stays within its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= CNT_W'(QUEUE_DEPTH))
    else $error("item queue level above depth");

    // the input side only stalls behind a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (q_level == CNT_W'(QUEUE_DEPTH)))
    else $error("s_tready low with room in the queue");

    // a pop without a push drops the level by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_out_valid && q_out_ready && !(front_valid && q_in_ready))
        |=> (q_level == $past(q_level) - 1'b1))
    else $error("queue level out of step with transactions");

endmodule

// ===== tb/tb_catmull_rom_spline_point_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_catmull_rom_spline_point_unit: self-checking bench for the spline unit
// Streams control-point quads and step indexes into the unit under several
// step_count settings. It predicts each curve point in fixed point and checks every
// returned point in order, with random gaps and stalls on both streams in some phases.
// ============================================================================
module tb_catmull_rom_spline_point_unit;

    localparam int STEP_BITS   = 10;
    localparam int IN_W        = ((8*crsp_pkg::COORD_W + STEP_BITS + 7) / 8) * 8;
    localparam int PAD_W       = IN_W - 8*crsp_pkg::COORD_W - STEP_BITS;
    localparam int C_HI        = 2**23 - 1;
    localparam int C_LO        = -(2**23);
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        crsp_pkg::coord_t      p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
        logic [STEP_BITS-1:0]  step_index;
    } spline_item_t;

    typedef struct packed {
        crsp_pkg::coord_t point_x;
        crsp_pkg::coord_t point_y;
        logic             out_of_range;
    } curve_point_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*crsp_pkg::COORD_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [STEP_BITS-1:0]  cfg_data = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    spline_item_t          pending_items[$];
    curve_point_t          expected_points[$];
    spline_item_t          drv_item;
    curve_point_t          want, got;
    logic [STEP_BITS-1:0]  step_count_model = STEP_BITS'(crsp_pkg::STEP_COUNT_RESET);
    bit                    idle_enable = 1'b1;
    bit                    s_taken = 1'b0;
    int                    items_left = 0;
    int                    send_gap = 0;
    int                    stall_left = 0;
    int                    fail_count = 0;
    int                    points_checked = 0;
    int                    oor_seen = 0;
    int                    settings_used = 1;
    int                    cycle_count = 0;

    catmull_rom_spline_point_unit #(
        .STEP_BITS (STEP_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point curve predictor
    // ------------------------------------------------------------------
    function automatic crsp_pkg::coord_t axis_point(longint a0, longint a1,
                                                    longint a2, longint a3,
                                                    longint w0, longint w1,
                                                    longint w2, longint w3);
        longint acc, mag, q;
        acc = 2*w0*a1 + 2*w1*a2 + w2*(a2 - a0) + w3*(a3 - a1);
        mag = (acc < 0) ? -acc : acc;
        // divide by 2^17, round half away from zero
        q = (mag + 65536) >>> 17;
        q = (acc < 0) ? -q : q;
        if (q > C_HI) q = C_HI;
        if (q < C_LO) q = C_LO;
        return crsp_pkg::coord_t'(q);
    endfunction

    function automatic curve_point_t predict_point(spline_item_t it,
                                                   logic [STEP_BITS-1:0] count);
        longint t, n, s, sq, cu, w0, w1, w2, w3;
        curve_point_t r;
        t = it.step_index;
        n = count;
        if (t >= n) begin
            // past the end (or zero step count): s clamps to 1, P2 exactly
            r.point_x = it.p2_x;
            r.point_y = it.p2_y;
            r.out_of_range = 1'b1;
            return r;
        end
        s  = (t << 16) / n;
        sq = (s * s) >>> 16;
        cu = (sq * s) >>> 16;
        w0 = 2*cu - 3*sq + 65536;
        w1 = -2*cu + 3*sq;
        w2 = cu - 2*sq + s;
        w3 = cu - sq;
        r.point_x = axis_point(it.p0_x, it.p1_x, it.p2_x, it.p3_x, w0, w1, w2, w3);
        r.point_y = axis_point(it.p0_y, it.p1_y, it.p2_y, it.p3_y, w0, w1, w2, w3);
        r.out_of_range = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic spline_item_t make_quad(int x0, int y0, int x1, int y1,
                                               int x2, int y2, int x3, int y3, int t);
        spline_item_t it;
        it.p0_x = crsp_pkg::coord_t'(x0);  it.p0_y = crsp_pkg::coord_t'(y0);
        it.p1_x = crsp_pkg::coord_t'(x1);  it.p1_y = crsp_pkg::coord_t'(y1);
        it.p2_x = crsp_pkg::coord_t'(x2);  it.p2_y = crsp_pkg::coord_t'(y2);
        it.p3_x = crsp_pkg::coord_t'(x3);  it.p3_y = crsp_pkg::coord_t'(y3);
        it.step_index = STEP_BITS'(t);
        return it;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(5))
            0:       return C_LO;
            1:       return C_HI;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return int'(crsp_pkg::coord_t'($urandom));
        endcase
    endfunction

    function automatic int pick_step(int n);
        if (n == 0 || $urandom_range(99) >= 88)
            return (n == 0) ? $urandom_range(1023, 0) : $urandom_range(1023, n);
        return $urandom_range(n - 1, 0);
    endfunction

    function automatic spline_item_t make_random_item(int n);
        int c[8];
        int style, base_x, base_y, spread;
        style = $urandom_range(99);
        if (style < 65) begin
            // smooth run of neighboring control points
            base_x = $urandom_range(2*(2**20), 0) - 2**20;
            base_y = $urandom_range(2*(2**20), 0) - 2**20;
            spread = 1 << $urandom_range(16, 2);
            c[0] = base_x;
            c[1] = base_y;
            for (int k = 2; k < 8; k++)
                c[k] = c[k-2] + $urandom_range(2*spread, 0) - spread;
            return make_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], pick_step(n));
        end
        if (style < 85) begin
            return make_quad($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        for (int k = 0; k < 8; k++)
            c[k] = edge_coord();
        return make_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], pick_step(n));
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic queue_item(input spline_item_t it);
        pending_items = {pending_items, it};
        items_left++;
    endtask

    task automatic run_batch(input int count);
        for (int k = 0; k < count; k++)
            queue_item(make_random_item(step_count_model));
    endtask

    task automatic wait_drained();
        while (items_left != 0 || expected_points.size() != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_step_count(input logic [STEP_BITS-1:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        step_count_model = value;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // hold the current transaction
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap--;
        end else if (pending_items.size() > 0) begin
            drv_item = pending_items.pop_front();
            s_tdata  <= {{PAD_W{1'b0}}, drv_item.step_index,
                         drv_item.p3_y, drv_item.p3_x, drv_item.p2_y, drv_item.p2_x,
                         drv_item.p1_y, drv_item.p1_x, drv_item.p0_y, drv_item.p0_x};
            s_tvalid <= 1'b1;
            send_gap = (idle_enable && $urandom_range(99) < 25) ? pick_idle_len() : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
        s_taken = 1'b0;
    end

    // result-side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_enable && $urandom_range(99) < 20) begin
            m_tready <= 1'b0;
            stall_left = pick_idle_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then record new input transactions
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d points outstanding",
                     cycle_count, expected_points.size());
            $display("== FAIL ==");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.point_x      = m_tdata[crsp_pkg::COORD_W-1:0];
            got.point_y      = m_tdata[2*crsp_pkg::COORD_W-1:crsp_pkg::COORD_W];
            got.out_of_range = m_tuser;
            if (expected_points.size() == 0) begin
                $error("unexpected result transaction: x=%0d y=%0d oor=%0b",
                       got.point_x, got.point_y, got.out_of_range);
                fail_count++;
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (want.out_of_range) oor_seen++;
                if (got.point_x !== want.point_x) begin
                    $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
                    fail_count++;
                end
                if (got.point_y !== want.point_y) begin
                    $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
                    fail_count++;
                end
                if (got.out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %0b, got %0b",
                           want.out_of_range, got.out_of_range);
                    fail_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_points = {expected_points, predict_point(drv_item, step_count_model)};
            items_left--;
            s_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int rnd_count;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases at the reset step count of 100
        queue_item(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 0));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 50));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 1));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 99));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 100));
        queue_item(make_quad(-512, 256, 1000, -2000, 3000, 4000, 5000, -6000, 1023));
        queue_item(make_quad(C_HI, C_HI, C_HI, C_HI, C_HI, C_HI, C_HI, C_HI, 37));
        queue_item(make_quad(C_LO, C_LO, C_LO, C_LO, C_LO, C_LO, C_LO, C_LO, 63));
        // large tangents push the curve past the coordinate range both ways
        queue_item(make_quad(C_LO, C_HI, C_HI, C_LO, C_HI, C_LO, C_HI, C_LO, 30));
        queue_item(make_quad(C_HI, C_LO, C_LO, C_HI, C_LO, C_HI, C_LO, C_HI, 30));
        queue_item(make_quad(C_LO, C_HI, C_HI, C_LO, C_LO, C_HI, C_HI, C_LO, 70));
        queue_item(make_quad(-1, 1, 1, -1, -1, 1, 1, -1, 33));
        queue_item(make_quad(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
                             24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 10'h155));
        queue_item(make_quad(24'haaaaaa, 24'h555555, 24'h555555, 24'haaaaaa,
                             24'haaaaaa, 24'h555555, 24'h555555, 24'haaaaaa, 10'h2aa));
        run_batch(60);
        wait_drained();

        // single step per segment: only step 0 is in range
        write_step_count(1);
        queue_item(make_quad(100, 200, 300, 400, 500, 600, 700, 800, 0));
        queue_item(make_quad(100, 200, 300, 400, 500, 600, 700, 800, 1));
        idle_enable = 1'b0;
        run_batch(40);
        wait_drained();

        write_step_count(10'd1023);
        queue_item(make_quad(C_LO, C_HI, 0, 0, C_HI, C_LO, 0, 0, 1022));
        queue_item(make_quad(C_LO, C_HI, 0, 0, C_HI, C_LO, 0, 0, 1023));
        idle_enable = 1'b1;
        run_batch(90);
        wait_drained();

        // zero step count: everything is past the end
        write_step_count(0);
        queue_item(make_quad(1, 2, 3, 4, 5, 6, 7, 8, 0));
        run_batch(20);
        wait_drained();

        write_step_count(2);
        idle_enable = 1'b0;
        run_batch(40);
        wait_drained();

        for (int k = 0; k < 4; k++) begin
            write_step_count(STEP_BITS'($urandom_range(1023, 1)));
            idle_enable = k[0];
            rnd_count = 70;
            run_batch(rnd_count);
            wait_drained();
        end

        write_step_count(STEP_BITS'(crsp_pkg::STEP_COUNT_RESET));
        idle_enable = 1'b1;
        run_batch(80);
        wait_drained();

        write_step_count(3);
        run_batch(30);
        wait_drained();

        $display("Checked %0d curve points across %0d step_count settings,",
                 points_checked, settings_used);
        $display("%0d of them past the segment end; %0d mismatches.",
                 oor_seen, fail_count);
        if (fail_count == 0 && expected_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/crsp_pkg.sv
src/crsp_front.sv
src/crsp_fifo.sv
src/crsp_div.sv
src/crsp_back.sv
src/catmull_rom_spline_point_unit.sv
tb/tb_catmull_rom_spline_point_unit.sv
